FILE: rtl/core/bat_pkg.sv
// Shared constants and types for the breakpoint address table.
package bat_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 16;
    localparam int ADDR_W     = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int OPCODE_W   = 3;
    localparam int COUNT_W    = 5;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    // Command codes.
    localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CHECK  = 3'd4;

    // Write port of the slot store.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] data;
    } t_slot_wr;

    // One result beat.
    typedef struct packed {
        logic               status;
        logic               hit;
        logic [COUNT_W-1:0] entry_count;
        logic [ADDR_W-1:0]  entry_address;
        logic               last;
    } t_result;

endpackage

FILE: rtl/core/bat_slot_store.sv
// Slot array of the breakpoint table with one read and one write port.
module bat_slot_store import bat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_wr          i_wr,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [ADDR_W-1:0] o_rd_data
);

    logic [ADDR_W-1:0] r_slots [SLOT_COUNT];

    // Reset empties every slot; otherwise one slot is written per cycle while the write port is enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_slots[i_wr.idx] <= i_wr.data;
        end
    end

    // The scan reads the slot under its pointer.
    assign o_rd_data = r_slots[i_rd_idx];

endmodule

FILE: rtl/core/bat_seq.sv
// Command sequencer: walks the slots one per cycle through a shared comparator; listing waits for output room.
module bat_seq import bat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic                i_out_free,
    input  logic [ADDR_W-1:0]   i_rd_data,
    output logic [IDX_W-1:0]    o_rd_idx,
    output t_slot_wr            o_wr,
    output logic                o_res_load,
    output t_result             o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state              r_state,  n_state;
    logic [OPCODE_W-1:0] r_op,     n_op;
    logic [ADDR_W-1:0]   r_addr,   n_addr;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [CNT_W-1:0]    r_k,      n_k;
    logic                r_status, n_status;
    logic                r_hit,    n_hit;

    logic             s_eq;
    logic             s_empty;
    logic             s_scan_end;
    logic             s_done;
    logic [CNT_W-1:0] s_k_next;

    // Shared comparator on the slot under the pointer.
    assign s_eq       = (i_rd_data == r_addr);
    assign s_empty    = (i_rd_data == '0);
    assign s_scan_end = (r_idx == IDX_LAST);
    assign s_k_next   = r_k + 1'b1;
    assign o_rd_idx   = r_idx;

    // Next-state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_status   = r_status;
        n_hit      = r_hit;
        o_in_ready = 1'b0;
        o_wr       = '0;
        o_res_load = 1'b0;
        o_res      = '0;
        s_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_addr   = i_address;
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_status = 1'b0;
                    n_hit    = 1'b0;
                    // Unused codes go straight to a result that is zero but for its last flag.
                    n_state  = (i_opcode <= OP_CHECK) ? S_SCAN : S_EMIT;
                end
            end

            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                unique case (r_op)
                    OP_ADD: begin
                        if (s_eq) begin
                            s_done = 1'b1;
                        end else if (s_empty) begin
                            o_wr.en   = 1'b1;
                            o_wr.idx  = r_idx;
                            o_wr.data = r_addr;
                            s_done    = 1'b1;
                        end else if (s_scan_end) begin
                            n_status = 1'b1;
                            s_done   = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (s_eq) begin
                            o_wr.en  = 1'b1;
                            o_wr.idx = r_idx;
                        end
                        s_done = s_scan_end;
                    end
                    OP_CLEAR: begin
                        o_wr.en  = 1'b1;
                        o_wr.idx = r_idx;
                        s_done   = s_scan_end;
                    end
                    OP_QUERY: begin
                        if (!s_empty) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        s_done = s_scan_end;
                    end
                    OP_CHECK: begin
                        if (s_eq && !s_empty) begin
                            n_hit = 1'b1;
                        end
                        s_done = s_scan_end;
                    end
                    default: begin
                        s_done = 1'b1;
                    end
                endcase
                if (s_done) begin
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (i_out_free) begin
                    o_res_load      = 1'b1;
                    o_res.status    = r_status;
                    o_res.hit       = r_hit;
                    o_res.entry_count = (r_op == OP_QUERY) ? COUNT_W'(r_cnt) : '0;
                    // A query of a non-empty table continues with its entries.
                    if (r_op == OP_QUERY && r_cnt != '0) begin
                        o_res.last = 1'b0;
                        n_idx      = '0;
                        n_k        = '0;
                        n_state    = S_LIST;
                    end else begin
                        o_res.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end

            S_LIST: begin
                if (s_empty) begin
                    n_idx = r_idx + 1'b1;
                end else if (i_out_free) begin
                    o_res_load          = 1'b1;
                    o_res.entry_address = i_rd_data;
                    o_res.last          = (s_k_next == r_cnt);
                    n_k                 = s_k_next;
                    n_idx               = r_idx + 1'b1;
                    if (s_k_next == r_cnt) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_status <= n_status;
        r_hit    <= n_hit;
    end

endmodule

FILE: rtl/core/breakpoint_address_table.sv
// Breakpoint address table: top level with the result output register.
//
// A table of SLOT_COUNT 16-bit breakpoint addresses; zero marks an empty slot.
// Commands arrive on the input channel (i_in_valid / o_in_ready) as an opcode
// and an address: add, remove, clear all, query list and check address.
// Results leave on the output channel (o_out_valid / i_out_ready); the last
// beat of every command carries o_last.
// Each command walks the slot array one slot per cycle through one comparator;
// the listing pass of a query holds while the output register is not free,
// and unused codes skip the walk. The result is loaded into the output
// register once the walk ends and the register is free. Add stops at the
// first equal or empty slot. A query makes a counting pass, then a listing
// pass that gives one beat per occupied slot. The input is not ready until
// the last beat is loaded.
// The result sits in an output register: a stalled receiver holds the beat
// and the sequencer waits; the next command is taken while the last beat of
// the previous one is still waiting.
// Reset is synchronous and active low; it empties the table at once.
module breakpoint_address_table import bat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [ADDR_W-1:0]   i_address,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_status,
    output logic                o_hit,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic [ADDR_W-1:0]   o_entry_address,
    output logic                o_last
);

    logic              r_out_valid;
    t_result           r_out;
    logic              s_out_free;
    logic [IDX_W-1:0]  s_rd_idx;
    logic [ADDR_W-1:0] s_rd_data;
    t_slot_wr          s_wr;
    logic              s_res_load;
    t_result           s_res;

    bat_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (s_wr),
        .i_rd_idx  (s_rd_idx),
        .o_rd_data (s_rd_data)
    );

    bat_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .i_out_free (s_out_free),
        .i_rd_data  (s_rd_data),
        .o_rd_idx   (s_rd_idx),
        .o_wr       (s_wr),
        .o_res_load (s_res_load),
        .o_res      (s_res)
    );

    // The output register can take a new beat when empty or being drained.
    assign s_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_load) begin
            r_out <= s_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_hit           = r_out.hit;
    assign o_entry_count   = r_out.entry_count;
    assign o_entry_address = r_out.entry_address;
    assign o_last          = r_out.last;

    // A beat is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_load |-> s_out_free)
        else $error("result loaded while output beat pending");

    // The table is only written while a command is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr.en |-> !o_in_ready)
        else $error("slot write while idle");

    // Results are only produced while a command is in progress.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_load |-> !o_in_ready)
        else $error("result loaded while idle");

    // A newly loaded beat appears on the output in the next cycle.
    a_load_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_load |=> o_out_valid)
        else $error("loaded beat not presented");

endmodule

FILE: test/tb_breakpoint_address_table.sv
// Testbench for the breakpoint address table: queued driver, checking monitor, table predictor.
`timescale 1ns / 100ps

module tb_breakpoint_address_table;
    import bat_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 40;
    localparam int PHASE_COUNT  = 4;

    // Opcodes that the block treats as no-ops.
    localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = OP_CHECK + 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TOP          = '1;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [ADDR_W-1:0]   addr;
    } t_command;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode        = '0;
    logic [ADDR_W-1:0]   address       = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic                status;
    logic                hit;
    logic [COUNT_W-1:0]  entry_count;
    logic [ADDR_W-1:0]   entry_address;
    logic                res_last;

    // Commands waiting to be driven and result beats still owed by the block.
    t_command          cmd_backlog[$];
    t_result           owed_beats[$];
    logic [ADDR_W-1:0] bp_slots[SLOT_COUNT];
    logic [ADDR_W-1:0] addr_pool[8];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    logic        took_cmd       = 1'b0;

    breakpoint_address_table u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_address       (address),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_hit           (hit),
        .o_entry_count   (entry_count),
        .o_entry_address (entry_address),
        .o_last          (res_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** breakpoint_address_table: FAILED **");
            $finish;
        end
    end

    // Computes the result beats of one accepted command and updates the table copy.
    function automatic void predict_command(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] a);
        t_result     beat;
        int unsigned used;
        int unsigned listed;
        bit          placed;
        beat      = '0;
        beat.last = 1'b1;
        case (op)
            OP_ADD: begin
                // The scan stops at the first equal entry or the first empty slot.
                placed = 1'b0;
                for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
                    if (bp_slots[i] == a) begin
                        placed = 1'b1;
                    end else if (bp_slots[i] == '0) begin
                        bp_slots[i] = a;
                        placed      = 1'b1;
                    end
                end
                beat.status = !placed;
                owed_beats.push_back(beat);
            end
            OP_REMOVE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (bp_slots[i] == a) begin
                        bp_slots[i] = '0;
                    end
                end
                owed_beats.push_back(beat);
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    bp_slots[i] = '0;
                end
                owed_beats.push_back(beat);
            end
            OP_QUERY: begin
                // A count beat, then one beat per occupied slot in slot order.
                used = 0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (bp_slots[i] != '0) begin
                        used++;
                    end
                end
                beat.entry_count = COUNT_W'(used);
                beat.last        = (used == 0);
                owed_beats.push_back(beat);
                listed = 0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (bp_slots[i] != '0) begin
                        listed             = listed + 1;
                        beat               = '0;
                        beat.entry_address = bp_slots[i];
                        beat.last          = (listed == used);
                        owed_beats.push_back(beat);
                    end
                end
            end
            OP_CHECK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (bp_slots[i] != '0 && bp_slots[i] == a) begin
                        beat.hit = 1'b1;
                    end
                end
                owed_beats.push_back(beat);
            end
            default: begin
                owed_beats.push_back(beat);
            end
        endcase
    endfunction

    // Driver: presents commands at the falling edge and holds each until it is taken.
    always @(negedge clk) begin
        t_command cmd;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (!in_valid || took_cmd) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd = cmd_backlog.pop_front();
                    opcode   <= cmd.op;
                    address  <= cmd.addr;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every accepted command and checks every accepted result beat.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (!rst_n) begin
            took_cmd <= 1'b0;
        end else begin
            took_cmd <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                predict_command(opcode, address);
            end
            if (out_valid && out_ready) begin
                got = '{status, hit, entry_count, entry_address, res_last};
                if (owed_beats.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("unexpected result beat: status %b hit %b count %0d addr %h last %b",
                                 got.status, got.hit, got.entry_count, got.entry_address,
                                 got.last);
                    end
                    fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    if (got.status !== want.status || got.hit !== want.hit ||
                        got.entry_count !== want.entry_count ||
                        got.entry_address !== want.entry_address ||
                        got.last !== want.last) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("result mismatch at cycle %0d:", cycle_count);
                            $display("  expected status %b hit %b count %0d addr %h last %b",
                                     want.status, want.hit, want.entry_count,
                                     want.entry_address, want.last);
                            $display("  actual   status %b hit %b count %0d addr %h last %b",
                                     got.status, got.hit, got.entry_count,
                                     got.entry_address, got.last);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic push_cmd(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] a);
        t_command cmd;
        cmd.op   = op;
        cmd.addr = a;
        cmd_backlog.push_back(cmd);
    endtask

    // Holds the stimulus back until every command is taken and every beat has come.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_valid || owed_beats.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // One random command, with addresses drawn mostly from a small pool so that hits,
    // duplicates and removals are common.
    task automatic push_random_cmd();
        int unsigned         r;
        logic [OPCODE_W-1:0] op;
        logic [ADDR_W-1:0]   a;
        r = $urandom_range(0, 99);
        if (r < 38) begin
            op = OP_ADD;
        end else if (r < 53) begin
            op = OP_REMOVE;
        end else if (r < 72) begin
            op = OP_CHECK;
        end else if (r < 86) begin
            op = OP_QUERY;
        end else if (r < 91) begin
            op = OP_CLEAR;
        end else begin
            op = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_TOP));
        end
        if ($urandom_range(0, 99) < 65) begin
            a = addr_pool[$urandom_range(0, 7)];
        end else begin
            a = ADDR_W'($urandom_range(0, 16'hFFFF));
        end
        push_cmd(op, a);
    endtask

    // Fills the table past capacity, then probes the full table.
    task automatic push_fill_burst();
        for (int i = 0; i <= SLOT_COUNT; i++) begin
            push_cmd(OP_ADD, ADDR_W'($urandom_range(1, 16'hFFFF)));
        end
        push_cmd(OP_ADD, '0);
        push_cmd(OP_ADD, addr_pool[$urandom_range(1, 7)]);
        push_cmd(OP_QUERY, ADDR_W'($urandom_range(0, 16'hFFFF)));
        push_cmd(OP_CHECK, '0);
    endtask

    // Stimulus sequence: reset, directed commands, then random phases with varied idling.
    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            bp_slots[i] = '0;
        end
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            addr_pool[i] = ADDR_W'($urandom_range(1, 16'hFFFE));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, zero address, extremes, holes and duplicates.
        push_cmd(OP_QUERY, '0);
        push_cmd(OP_CHECK, '0);
        push_cmd(OP_ADD, '0);
        push_cmd(OP_ADD, 16'hFFFF);
        push_cmd(OP_ADD, 16'h0001);
        push_cmd(OP_ADD, 16'hFFFF);
        push_cmd(OP_REMOVE, '0);
        push_cmd(OP_CHECK, 16'hFFFF);
        push_cmd(OP_CHECK, 16'h1234);
        push_cmd(OP_ADD, 16'h8000);
        push_cmd(OP_REMOVE, 16'hFFFF);
        // The hole in slot zero takes a copy of an address already present further on.
        push_cmd(OP_ADD, 16'h0001);
        push_cmd(OP_QUERY, 16'hFFFF);
        push_cmd(OP_REMOVE, 16'h0001);
        push_cmd(OP_QUERY, '0);
        push_cmd(OP_FIRST_UNUSED, 16'hFFFF);
        push_cmd(OP_FIRST_UNUSED + 3'd1, 16'h5555);
        push_cmd(OP_TOP, 16'hAAAA);
        push_cmd(OP_CLEAR, 16'hFFFF);
        push_cmd(OP_CHECK, 16'h8000);
        push_cmd(OP_QUERY, '0);
        wait_drained();

        // Random part over four idling phases.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
                push_random_cmd();
                if (n == RANDOM_ITEMS / (2 * PHASE_COUNT) && (ph % 2) == 1) begin
                    push_fill_burst();
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_beats.size() == 0) begin
            $display("** breakpoint_address_table: PASSED **");
        end else begin
            $display("** breakpoint_address_table: FAILED **");
        end
        $finish;
    end

endmodule
